@@ design/cids_pkg.sv @@
// Shared types and constants for the card id slot table.
// No dependencies; imported by card_id_slot_table, cids_ctrl and the testbench.
package cids_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_COUNT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // key memory access from the sequencer
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [KEY_BITS-1:0] wdata;
    logic                re;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] free_cnt;
  } result_t;

endpackage

@@ design/card_id_slot_table.sv @@
// Card id slot table. A request first walks the slots it needs (find, add, remove; a rejected
// remove or a count has no request walk), then the free count walks the active slots (up to 16)
// and the result is taken into the output register.
// Throughput: one request at a time, the next taken the cycle after the result is registered;
// the one-slot-per-cycle walk over key memory and valid bits sets it. A waiting result does
// not block the next request. Reset: valid bits cleared at once (table empty), active size 16;
// keys of empty slots never reach a result, so no clearing pass.
module card_id_slot_table
  import cids_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: active size
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // request beat
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] card_key_i,
  input  logic [4:0]  slot_index_i,
  // result beat
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  free_count_o
);

  logic [4:0]          act_size_q;
  logic [CNT_W-1:0]    used;
  logic                accept, busy, done, take;
  result_t             res;
  mem_req_t            mem_req;
  logic [KEY_BITS-1:0] rdata;
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [3:0]          slot_q;
  logic [4:0]          free_q;

  // active size register; values above the depth act as the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_size_q <= 5'd16;
    end else if (cfg_we_i) begin
      act_size_q <= cfg_wdata_i;
    end
  end

  assign used = (int'(act_size_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(act_size_q);

  // one request in flight; the sequencer stalls the input while busy
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;
  // result register can take a new beat when empty or draining
  assign take       = !out_valid_q || !out_stall_i;

  cids_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .func_i  (func_e'(func_i)),
    .key_i   (card_key_i[KEY_BITS-1:0]),
    .idx_i   (slot_index_i),
    .used_i  (used),
    .take_i  (take),
    .rdata_i (rdata),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res),
    .mem_o   (mem_req)
  );

  // key store, one slot per entry
  cids_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q <= 2'(res.status);
      slot_q   <= 4'(res.slot);
      free_q   <= 5'(res.free_cnt);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign free_count_o = free_q;

`ifndef NO_ASSERTIONS
  a_done_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("finished result did not reach output register");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (slot_o == 4'd0))
    else $error("slot nonzero on failed request");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CNT_W'(free_count_o) <= used))
    else $error("free count above active size");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("key memory read and write hit same slot");
`endif

endmodule

@@ design/cids_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cids_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ design/cids_ctrl.sv @@
// Request sequencer: walks the slots one per cycle, holds the valid bits.
// Depends on cids_pkg; drives the key memory through a mem_req_t.
module cids_ctrl
  import cids_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  func_e               func_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [4:0]          idx_i,
  input  logic [CNT_W-1:0]    used_i,
  input  logic                take_i,
  input  logic [KEY_BITS-1:0] rdata_i,
  output logic                busy_o,
  output logic                done_o,
  output result_t             res_o,
  output mem_req_t            mem_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_ADD   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_COUNT = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       i_q, i_d;
  logic                   pend_q, pend_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  status_e                status_q, status_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic [CNT_W-1:0]       free_q, free_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]       cur_idx, last_idx, prev_idx;
  logic                   more, hit;

  assign cur_idx  = i_q[IDX_W-1:0];
  assign last_idx = IDX_W'(used_i - CNT_W'(1));
  assign prev_idx = pidx_q - IDX_W'(1);
  assign more     = (i_q < used_i);
  // data for pidx_q came back this cycle
  assign hit      = pend_q && valid_q[pidx_q] && (rdata_i == key_q);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    key_d    = key_q;
    status_d = status_q;
    slot_d   = slot_q;
    free_d   = free_q;
    valid_d  = valid_q;
    done_o   = 1'b0;
    mem_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d    = key_i;
          status_d = ST_OK;
          slot_d   = '0;
          free_d   = '0;
          i_d      = '0;
          unique case (func_i)
            FUNC_FIND: state_d = S_FIND;
            FUNC_ADD:  state_d = S_ADD;
            FUNC_REMOVE: begin
              if (int'(idx_i) >= int'(used_i)) begin
                status_d = ST_RANGE;
                state_d  = S_COUNT;
              end else begin
                slot_d  = IDX_W'(idx_i);
                i_d     = CNT_W'(idx_i) + CNT_W'(1);
                state_d = S_SHIFT;
              end
            end
            FUNC_COUNT: state_d = S_COUNT;
            default:    state_d = S_COUNT;
          endcase
        end
      end

      S_FIND: begin
        if (hit) begin
          slot_d  = pidx_q;
          i_d     = '0;
          state_d = S_COUNT;
        end else if (more) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = cur_idx;
          pend_d      = 1'b1;
          pidx_d      = cur_idx;
          i_d         = i_q + CNT_W'(1);
        end else if (!pend_q) begin
          status_d = ST_NOT_FOUND;
          i_d      = '0;
          state_d  = S_COUNT;
        end
      end

      S_ADD: begin
        if (!more) begin
          status_d = ST_FULL;
          i_d      = '0;
          state_d  = S_COUNT;
        end else if (!valid_q[cur_idx]) begin
          mem_o.we         = 1'b1;
          mem_o.waddr      = cur_idx;
          mem_o.wdata      = key_q;
          valid_d[cur_idx] = 1'b1;
          slot_d           = cur_idx;
          i_d              = '0;
          state_d          = S_COUNT;
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        // read slot i, write its data one slot lower when the read returns
        if (pend_q) begin
          mem_o.we          = 1'b1;
          mem_o.waddr       = prev_idx;
          mem_o.wdata       = rdata_i;
          valid_d[prev_idx] = valid_q[pidx_q];
        end
        if (more) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = cur_idx;
          pend_d      = 1'b1;
          pidx_d      = cur_idx;
          i_d         = i_q + CNT_W'(1);
        end else if (!pend_q) begin
          state_d = S_CLEAR;
        end
      end

      S_CLEAR: begin
        mem_o.we          = 1'b1;
        mem_o.waddr       = last_idx;
        mem_o.wdata       = '0;
        valid_d[last_idx] = 1'b0;
        i_d               = '0;
        state_d           = S_COUNT;
      end

      S_COUNT: begin
        if (more) begin
          if (!valid_q[cur_idx]) begin
            free_d = free_q + CNT_W'(1);
          end
          i_d = i_q + CNT_W'(1);
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (take_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    key_q    <= key_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    free_q   <= free_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign res_o.status   = status_q;
  assign res_o.slot     = slot_q;
  assign res_o.free_cnt = free_q;

endmodule

@@ verif/card_id_slot_table_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for card_id_slot_table: directed table, then random phases.
// Depends on cids_pkg (types, codes) and the card_id_slot_table RTL; needs nothing else.
module card_id_slot_table_test;
  import cids_pkg::*;

  localparam int          WATCHDOG_LIMIT  = 2000;  // cycles with no beat on any side
  localparam int          SETTLE_CYCLES   = 64;    // length of the late window at the end
  localparam int          ITEMS_PER_PHASE = 180;
  localparam int          QUIET_PHASE     = 4;     // phase run with no idling at all
  localparam logic [63:0] KEY_ONES        = {64{1'b1}};
  localparam logic [63:0] KEY_MIX         = 64'h8000_0000_0000_0001;
  localparam logic [63:0] KEY_A5          = 64'hA5A5_5A5A_0F0F_F0F0;

  // one row of the directed table: either a size write or a request beat
  typedef struct packed {
    logic        is_cfg;
    logic [4:0]  size;
    func_e       func;
    logic [63:0] key;
    logic [4:0]  idx;
    logic        typed;   // want holds a hand-written result
    result_t     want;
  } row_t;

  localparam int NUM_ROWS = 26;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // fresh table, active size 16
    '{1'b0, 5'd0,  FUNC_COUNT,  64'd0,    5'd0,  1'b1, '{ST_OK,        4'd0, 5'd16}},
    // key zero must not match an empty slot
    '{1'b0, 5'd0,  FUNC_FIND,   64'd0,    5'd0,  1'b1, '{ST_NOT_FOUND, 4'd0, 5'd16}},
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd16, 1'b1, '{ST_RANGE,     4'd0, 5'd16}},
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd31, 1'b1, '{ST_RANGE,     4'd0, 5'd16}},
    // removing an empty slot is accepted
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd0,  1'b1, '{ST_OK,        4'd0, 5'd16}},
    '{1'b0, 5'd0,  FUNC_ADD,    KEY_ONES, 5'd0,  1'b1, '{ST_OK,        4'd0, 5'd15}},
    '{1'b0, 5'd0,  FUNC_ADD,    64'd0,    5'd0,  1'b1, '{ST_OK,        4'd1, 5'd14}},
    // duplicate key lands in a new slot, find still returns the lowest
    '{1'b0, 5'd0,  FUNC_ADD,    KEY_ONES, 5'd0,  1'b1, '{ST_OK,        4'd2, 5'd13}},
    '{1'b0, 5'd0,  FUNC_FIND,   KEY_ONES, 5'd0,  1'b1, '{ST_OK,        4'd0, 5'd13}},
    '{1'b0, 5'd0,  FUNC_ADD,    KEY_MIX,  5'd0,  1'b0, '0},
    // shift down from slot 0
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_FIND,   64'd0,    5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_FIND,   KEY_MIX,  5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd15, 1'b0, '0},
    // size 1: occupied slots above it are invisible
    '{1'b1, 5'd1,  FUNC_FIND,   64'd0,    5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_ADD,    KEY_A5,   5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_FIND,   KEY_ONES, 5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd1,  1'b1, '{ST_RANGE,     4'd0, 5'd0}},
    // size 0: nothing in use
    '{1'b1, 5'd0,  FUNC_FIND,   64'd0,    5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_FIND,   64'd0,    5'd0,  1'b1, '{ST_NOT_FOUND, 4'd0, 5'd0}},
    '{1'b0, 5'd0,  FUNC_ADD,    KEY_A5,   5'd0,  1'b1, '{ST_FULL,      4'd0, 5'd0}},
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd0,  1'b1, '{ST_RANGE,     4'd0, 5'd0}},
    '{1'b0, 5'd0,  FUNC_COUNT,  64'd0,    5'd0,  1'b1, '{ST_OK,        4'd0, 5'd0}},
    // size above depth acts as full depth
    '{1'b1, 5'd31, FUNC_FIND,   64'd0,    5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_COUNT,  64'd0,    5'd0,  1'b0, '0},
    '{1'b0, 5'd0,  FUNC_REMOVE, 64'd0,    5'd16, 1'b0, '0}
  };

  // active sizes of the random phases, extremes included
  localparam int NUM_PHASES = 11;
  localparam logic [4:0] PHASE_SIZES [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd2, 5'd5, 5'd16, 5'd0, 5'd31, 5'd8, 5'd17, 5'd3, 5'd16
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [63:0] card_key_i;
  logic [4:0]  slot_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [3:0]  slot_o;
  logic [4:0]  free_count_o;

  // shadow copy of the table and its size register
  logic [63:0] tbl_key [TABLE_DEPTH];
  logic        tbl_vld [TABLE_DEPTH];
  logic [4:0]  act_size;

  result_t     pending_results [$];
  logic [63:0] key_pool [8];
  bit          quiet;
  int          err_cnt;
  int          idle_cycles;

  card_id_slot_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .card_key_i   (card_key_i),
    .slot_index_i (slot_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .free_count_o (free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // slots taking part in a request; sizes above the depth clamp to it
  function automatic int used_slots();
    return (act_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(act_size);
  endfunction

  // Applies one request beat to the shadow table and returns its result.
  function automatic result_t apply_request(func_e f, logic [63:0] k, logic [4:0] idx);
    result_t r;
    int      n;
    int      i;
    int      free;
    n = used_slots();
    r = '0;
    r.status = ST_OK;
    case (f)
      FUNC_FIND: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < n; i++) begin
          if (r.status != ST_OK && tbl_vld[i] && tbl_key[i] == k) begin
            r.status = ST_OK;
            r.slot   = IDX_W'(i);
          end
        end
      end
      FUNC_ADD: begin
        r.status = ST_FULL;
        for (i = 0; i < n; i++) begin
          if (r.status != ST_OK && !tbl_vld[i]) begin
            tbl_key[i] = k;
            tbl_vld[i] = 1'b1;
            r.status   = ST_OK;
            r.slot     = IDX_W'(i);
          end
        end
      end
      FUNC_REMOVE: begin
        if (int'(idx) >= n) begin
          r.status = ST_RANGE;
        end else begin
          // everything above idx moves down one, last active slot emptied
          for (i = int'(idx); i + 1 < n; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_vld[i] = tbl_vld[i + 1];
          end
          tbl_key[n - 1] = '0;
          tbl_vld[n - 1] = 1'b0;
          r.slot         = IDX_W'(idx);
        end
      end
      default: ;  // count only reports
    endcase
    free = 0;
    for (i = 0; i < n; i++) begin
      if (!tbl_vld[i]) free++;
    end
    r.free_cnt = CNT_W'(free);
    return r;
  endfunction

  // Drives one request beat and holds it until accepted. Valid is only lowered
  // when a gap is taken, so back-to-back beats never toggle it within a step.
  task automatic send_req(func_e f, logic [63:0] k, logic [4:0] idx, bit typed,
                          result_t want);
    result_t predicted;
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    func_i       <= f;
    card_key_i   <= k;
    slot_index_i <= idx;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_request(f, k, idx);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // stop sending and wait for every outstanding result beat
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_size(logic [4:0] size);
    cfg_wdata_i <= size;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    act_size = size;
    cfg_we_i <= 1'b0;
  endtask

  // Random request: keys mostly from a small pool so finds hit and duplicates
  // pile up; remove indexes mostly inside the active size.
  task automatic send_random();
    int          pick;
    int          n;
    func_e       f;
    logic [63:0] k;
    logic [4:0]  idx;
    pick = $urandom_range(99);
    f = (pick < 30) ? FUNC_ADD : (pick < 60) ? FUNC_FIND :
        (pick < 88) ? FUNC_REMOVE : FUNC_COUNT;
    k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
    n = used_slots();
    idx = (n > 0 && $urandom_range(99) < 85) ? 5'($urandom_range(n - 1))
                                              : 5'($urandom_range(31));
    send_req(f, k, idx, 1'b0, '0);
  endtask

  // result side: random stall, none during the quiet phase
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // every accepted result beat is matched against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d slot %0d free_count %0d",
               status_o, slot_o, free_count_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_cnt++;
        end
        if (slot_o !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot_o);
          err_cnt++;
        end
        if (free_count_o !== want.free_cnt) begin
          $error("free_count: expected %0d, got %0d", want.free_cnt, free_count_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: any beat or size write counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= 5'd0;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_FIND;
    card_key_i   <= 64'd0;
    slot_index_i <= 5'd0;
    quiet        = 1'b0;
    err_cnt      = 0;
    idle_cycles  = 0;
    act_size     = 5'd16;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_key[i] = '0;
      tbl_vld[i] = 1'b0;
    end
    // pool with both all-zero and all-one keys so every key bit sees both values
    key_pool[0] = 64'd0;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; size writes wait until the block has gone idle
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].is_cfg) begin
        drain();
        write_size(DIRECTED[r].size);
      end else begin
        send_req(DIRECTED[r].func, DIRECTED[r].key, DIRECTED[r].idx,
                 DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // random phases, one active size each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_size(PHASE_SIZES[ph]);
      quiet = (ph == QUIET_PHASE);
      repeat (ITEMS_PER_PHASE) send_random();
    end
    quiet = 1'b0;

    drain();
    // late window: catches any stray result beat
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/cids_pkg.sv
design/cids_ram.sv
design/cids_ctrl.sv
design/card_id_slot_table.sv
verif/card_id_slot_table_test.sv
